// File: sv/bfct_pkg.sv
// package for the box frustum cull test unit
// holds opcodes, register indexes and shared widths; no dependencies
package bfct_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic signed [31:0] Q_ONE     = 32'sd65536;
    localparam logic signed [31:0] Q_NEG_ONE = -32'sd65536;
    localparam logic signed [31:0] S32_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;

    localparam int unsigned ACC_W = 50;
    localparam int unsigned REM_W = 66;
    localparam int unsigned DSH_W = 82;

endpackage

// File: sv/box_frustum_cull_test_unit.sv
// box frustum cull test unit: matrix store, corner sequencer, shared multiplier and divider
// depends on bfct_pkg
//
// channel   | handshake             | payload
// request   | start / busy          | i_opcode, i_entry_index, i_entry_value
// result    | o_valid (one cycle)   | o_visible
// config    | i_cfg_we              | i_cfg_index, i_cfg_data
//
// a load request writes one matrix entry and leaves busy low
// a test request keeps busy high while all 8 corners pass through the shared 32x32 multiplier
// and the one-bit-per-cycle divider; a zero w or a quotient overflow skips the divide;
// o_valid rises as busy falls
// synchronous active-low reset clears the matrix, the centre registers and the sequencer; the sizes reset to 65536
// the receiver cannot stall: o_valid is high for exactly one cycle
module box_frustum_cull_test_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [3:0]  i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic        i_cfg_we,
    input  logic [bfct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_visible
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CORNER = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_ACC    = 8'b0000_1000,
        S_DSET   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_DRES   = 8'b0100_0000,
        S_EVAL   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [31:0] r_mat [16];
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0] r_sx, r_sy, r_sz;

    logic [2:0] r_corner;
    logic [1:0] r_col, r_j;
    logic signed [31:0] r_x, r_y, r_z;
    logic signed [63:0] r_prod;
    logic signed [bfct_pkg::ACC_W-1:0] r_acc, r_w, r_num;
    logic [bfct_pkg::REM_W-1:0] r_rem;
    logic [bfct_pkg::DSH_W-1:0] r_dsh;
    logic [31:0] r_q;
    logic [4:0] r_cnt;
    logic r_neg, r_ovf, r_wzero;
    logic signed [31:0] r_px, r_pz;
    logic r_left, r_right, r_depth, r_vis;
    logic r_valid, r_visible;

    logic [1:0] col_sel;
    logic signed [31:0] coord_sel;
    logic signed [32:0] ax, ay, az;
    logic [bfct_pkg::ACC_W-1:0] an, aw;
    logic [bfct_pkg::REM_W-1:0] num_sh;
    logic [bfct_pkg::DSH_W-1:0] dsh_init, dov;
    logic [bfct_pkg::DSH_W-1:0] rem_ext;
    logic signed [31:0] qres;
    logic take;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > 33'sh0_7fff_ffff) return bfct_pkg::S32_MAX;
        if (v < -33'sh0_8000_0000) return bfct_pkg::S32_MIN;
        return v[31:0];
    endfunction

    assign take = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_visible = r_visible;

    always_comb begin
        unique case (r_col)
            2'd0:    col_sel = 2'd3;
            2'd1:    col_sel = 2'd0;
            default: col_sel = 2'd2;
        endcase
        unique case (r_j)
            2'd0:    coord_sel = r_x;
            2'd1:    coord_sel = r_y;
            default: coord_sel = r_z;
        endcase
    end

    // corner coordinates
    always_comb begin
        ax = r_corner[0] ? 33'(r_cx) + 33'(signed'({2'b0, r_sx[30:1]}))
                         : 33'(r_cx) - 33'(signed'({2'b0, r_sx[30:1]}));
        ay = r_corner[1] ? 33'(r_cy) - 33'(signed'({2'b0, r_sy[30:1]}))
                         : 33'(r_cy) + 33'(signed'({2'b0, r_sy[30:1]}));
        az = r_corner[2] ? 33'(r_cz) - 33'(signed'({2'b0, r_sz[30:1]}))
                         : 33'(r_cz) + 33'(signed'({2'b0, r_sz[30:1]}));
    end

    // divider setup
    always_comb begin
        an       = r_acc[bfct_pkg::ACC_W-1] ? bfct_pkg::ACC_W'(-r_acc) : r_acc;
        aw       = r_w[bfct_pkg::ACC_W-1] ? bfct_pkg::ACC_W'(-r_w) : r_w;
        num_sh   = {an, 16'b0};
        dsh_init = {1'b0, aw, 31'b0};
        dov      = {aw, 32'b0};
        rem_ext  = bfct_pkg::DSH_W'(r_rem);
    end

    // saturated signed quotient
    always_comb begin
        if (r_wzero) begin
            if (r_num > 0)      qres = bfct_pkg::S32_MAX;
            else if (r_num < 0) qres = bfct_pkg::S32_MIN;
            else                qres = '0;
        end else if (r_neg) begin
            if (r_ovf || r_q > 32'h8000_0000) qres = bfct_pkg::S32_MIN;
            else                             qres = -signed'(r_q);
        end else begin
            if (r_ovf || r_q[31]) qres = bfct_pkg::S32_MAX;
            else                  qres = signed'(r_q);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (take && i_opcode == bfct_pkg::OP_TEST) n_state = S_CORNER;
            S_CORNER: n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = (r_j == 2'd2) ? S_DSET : S_MUL;
            S_DSET: begin
                if (r_col == 2'd0)                                   n_state = S_MUL;
                else if (r_w == 0 || bfct_pkg::DSH_W'(num_sh) >= dov) n_state = S_DRES;
                else                                                 n_state = S_DIV;
            end
            S_DIV:    if (r_cnt == 5'd0) n_state = S_DRES;
            S_DRES:   n_state = (r_col == 2'd2) ? S_EVAL : S_MUL;
            S_EVAL:   n_state = (r_corner == 3'd7) ? S_IDLE : S_CORNER;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_visible <= 1'b0;
            r_cx <= '0; r_cy <= '0; r_cz <= '0;
            r_sx <= 31'd65536; r_sy <= 31'd65536; r_sz <= 31'd65536;
            for (int i = 0; i < 16; i++) r_mat[i] <= '0;
            r_corner <= '0; r_col <= '0; r_j <= '0; r_cnt <= '0;
            r_left <= 1'b0; r_right <= 1'b0; r_depth <= 1'b0; r_vis <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfct_pkg::CFG_CENTER_X: r_cx <= signed'(i_cfg_data);
                    bfct_pkg::CFG_CENTER_Y: r_cy <= signed'(i_cfg_data);
                    bfct_pkg::CFG_CENTER_Z: r_cz <= signed'(i_cfg_data);
                    bfct_pkg::CFG_SIZE_X:   r_sx <= i_cfg_data[30:0];
                    bfct_pkg::CFG_SIZE_Y:   r_sy <= i_cfg_data[30:0];
                    bfct_pkg::CFG_SIZE_Z:   r_sz <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take && i_opcode == bfct_pkg::OP_LOAD) r_mat[i_entry_index] <= i_entry_value;
                    r_corner <= '0;
                    r_left <= 1'b0; r_right <= 1'b0; r_depth <= 1'b0; r_vis <= 1'b0;
                end
                S_CORNER: begin
                    r_x <= sat33(ax);
                    r_y <= sat33(ay);
                    r_z <= sat33(az);
                    r_col <= 2'd0;
                    r_j <= 2'd0;
                end
                S_MUL: begin
                    r_prod <= 64'(coord_sel) * 64'(r_mat[{r_j, col_sel}]);
                    if (r_j == 2'd0) r_acc <= bfct_pkg::ACC_W'(r_mat[{2'd3, col_sel}]);
                end
                S_ACC: begin
                    r_acc <= r_acc + bfct_pkg::ACC_W'(r_prod >>> 16);
                    r_j   <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                end
                S_DSET: begin
                    if (r_col == 2'd0) begin
                        r_w   <= r_acc;
                        r_col <= 2'd1;
                    end else begin
                        r_num   <= r_acc;
                        r_wzero <= (r_w == 0);
                        r_neg   <= r_acc[bfct_pkg::ACC_W-1] != r_w[bfct_pkg::ACC_W-1];
                        r_ovf   <= bfct_pkg::DSH_W'(num_sh) >= dov;
                        r_rem   <= num_sh;
                        r_dsh   <= dsh_init;
                        r_q     <= '0;
                        r_cnt   <= 5'd31;
                    end
                end
                S_DIV: begin
                    if (rem_ext >= r_dsh) begin
                        r_rem <= bfct_pkg::REM_W'(rem_ext - r_dsh);
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 5'd1;
                end
                S_DRES: begin
                    if (r_col == 2'd1) begin
                        r_px  <= qres;
                        r_col <= 2'd2;
                    end else begin
                        r_pz  <= qres;
                    end
                end
                S_EVAL: begin
                    if (r_pz >= 0 && r_pz <= bfct_pkg::Q_ONE) begin
                        r_depth <= 1'b1;
                        if (r_px >= bfct_pkg::Q_NEG_ONE && r_px <= bfct_pkg::Q_ONE) r_vis <= 1'b1;
                    end
                    if (r_px < bfct_pkg::Q_NEG_ONE) r_left <= 1'b1;
                    else if (r_px > bfct_pkg::Q_ONE) r_right <= 1'b1;
                    r_corner <= r_corner + 3'd1;
                    if (r_corner == 3'd7) begin
                        r_valid   <= 1'b1;
                        r_visible <= r_vis
                            || (r_pz >= 0 && r_pz <= bfct_pkg::Q_ONE
                                && r_px >= bfct_pkg::Q_NEG_ONE && r_px <= bfct_pkg::Q_ONE)
                            || ((r_left || r_px < bfct_pkg::Q_NEG_ONE)
                                && (r_right || r_px > bfct_pkg::Q_ONE)
                                && (r_depth || (r_pz >= 0 && r_pz <= bfct_pkg::Q_ONE)));
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: sv/bfct_checker.sv
// port-level checks for the box frustum cull test unit
// depends on bfct_pkg and box_frustum_cull_test_unit; bound to the unit below
module bfct_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_opcode,
    input logic o_valid
);

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == bfct_pkg::OP_TEST) |=> busy)
        else $error("test request did not raise busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == bfct_pkg::OP_LOAD) |=> (!busy && !o_valid))
        else $error("load request caused work");

    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy)) else $error("result outside a test");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid)) else $error("reset did not clear");

endmodule

bind box_frustum_cull_test_unit bfct_checker u_bfct_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid)
);
